@@ rtl/shm_pkg.sv @@
// ----------------------------------------------------------------------------
// shm_pkg
// Shared types and constants for the sliding histogram median unit.
// ----------------------------------------------------------------------------
package shm_pkg;

    localparam int PIX_BITS   = 8;
    localparam int NUM_BINS   = 1 << PIX_BITS;
    localparam int BIN_W      = 10;
    localparam int RADIUS_W   = 4;
    localparam int MAX_RADIUS = 15;

    typedef logic [PIX_BITS-1:0] pix_t;
    typedef logic [BIN_W-1:0]    bin_t;
    typedef logic [RADIUS_W-1:0] radius_t;

    localparam pix_t    PIX_MAX     = pix_t'(NUM_BINS - 1);
    localparam bin_t    BIN_MAX     = '1;
    localparam bin_t    CNT_MAX     = '1;
    localparam radius_t RADIUS_CLIP = radius_t'(MAX_RADIUS);

    typedef struct packed {
        pix_t rd_addr;
        logic wr_en;
        pix_t wr_addr;
        bin_t wr_data;
        logic clear;
    } bin_req_t;

endpackage

@@ rtl/sliding_histogram_median_unit.sv @@
// ----------------------------------------------------------------------------
// sliding_histogram_median_unit
// Running median over a square pixel window kept as a 256-bin histogram.
// ----------------------------------------------------------------------------
// Sequence: a load goes through S_ADD, a slide through S_REM, S_ADD_RQ and
//   S_ADD, with one bin RAM access in flight at a time; an item marked last
//   adds one median search step per bin visited (scan from bin 0 after a load,
//   walk from the old median after a slide, at most 256 steps, one per cycle).
// Throughput: one item at a time, in_stall is high until the item is done.
// Reset: asynchronous; histogram reads as empty, median, below count and
//   error clear, radius becomes 1. No clearing pass is needed.
module sliding_histogram_median_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  shm_pkg::radius_t    cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                operation,
    input  shm_pkg::pix_t       add_pixel,
    input  shm_pkg::pix_t       remove_pixel,
    input  logic                first,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_stall,
    output shm_pkg::pix_t       median,
    output logic                count_error
);

    import shm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REM,
        S_ADD_RQ,
        S_ADD,
        S_SCAN,
        S_WALK,
        S_DOWN,
        S_UP
    } state_t;

    state_t   state_reg, state_next;
    logic     emit_reg, emit_next;
    logic     op_reg, op_next;
    logic     last_reg, last_next;
    pix_t     add_reg, add_next;
    pix_t     rem_reg, rem_next;
    bin_t     below_reg, below_next;
    pix_t     med_reg, med_next;
    logic     err_reg, err_next;
    pix_t     idx_reg, idx_next;
    bin_t     sum_reg, sum_next;
    radius_t  radius_reg, radius_next;
    logic     out_valid_reg, out_valid_next;
    pix_t     median_reg, median_next;
    logic     count_error_reg, count_error_next;

    bin_req_t           req;
    bin_t               bin_q;
    radius_t            r_eff;
    logic [4:0]         win_d;
    logic [9:0]         win_size;
    logic [8:0]         half;
    logic [8:0]         need;
    logic [BIN_W:0]     sum_ext;
    logic [BIN_W:0]     up_sum;
    bin_t               down_diff;

    shm_bins u_bins (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .bin_q (bin_q)
    );

    // window size from the clipped radius
    always_comb
    begin
        r_eff    = (radius_reg > RADIUS_CLIP) ? RADIUS_CLIP : radius_reg;
        win_d    = {r_eff, 1'b1};
        win_size = {5'd0, win_d} * {5'd0, win_d};
        half     = win_size[9:1];
        need     = win_size[9:1] + 9'd1;
    end

    assign sum_ext   = {1'b0, sum_reg} + {1'b0, bin_q};
    assign up_sum    = {1'b0, below_reg} + {1'b0, bin_q};
    assign down_diff = (below_reg >= bin_q) ? (below_reg - bin_q) : '0;

    always_comb
    begin
        state_next       = state_reg;
        emit_next        = emit_reg;
        op_next          = op_reg;
        last_next        = last_reg;
        add_next         = add_reg;
        rem_next         = rem_reg;
        below_next       = below_reg;
        med_next         = med_reg;
        err_next         = err_reg;
        idx_next         = idx_reg;
        sum_next         = sum_reg;
        radius_next      = radius_reg;
        out_valid_next   = out_valid_reg;
        median_next      = median_reg;
        count_error_next = count_error_reg;

        req         = '0;
        req.rd_addr = idx_reg;

        if (cfg_wr_en)
        begin
            radius_next = cfg_wr_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (emit_reg)
                begin
                    // result waits for a free output register
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_next   = 1'b1;
                        median_next      = med_reg;
                        count_error_next = err_reg;
                        err_next         = 1'b0;
                        emit_next        = 1'b0;
                    end
                end
                else if (in_valid)
                begin
                    op_next     = operation;
                    last_next   = last;
                    add_next    = add_pixel;
                    rem_next    = remove_pixel;
                    req.rd_addr = operation ? remove_pixel : add_pixel;
                    if (!operation && first)
                    begin
                        req.clear  = 1'b1;
                        below_next = '0;
                    end
                    state_next = operation ? S_REM : S_ADD;
                end
            end
            S_REM:
            begin
                if (bin_q == '0)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = rem_reg;
                    req.wr_data = bin_q - bin_t'(1);
                    if (rem_reg < med_reg && below_reg != '0)
                    begin
                        below_next = below_reg - bin_t'(1);
                    end
                end
                state_next = S_ADD_RQ;
            end
            S_ADD_RQ:
            begin
                req.rd_addr = add_reg;
                state_next  = S_ADD;
            end
            S_ADD:
            begin
                if (bin_q == BIN_MAX)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = add_reg;
                    req.wr_data = bin_q + bin_t'(1);
                    if (op_reg && add_reg < med_reg && below_reg != CNT_MAX)
                    begin
                        below_next = below_reg + bin_t'(1);
                    end
                end
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!op_reg)
                begin
                    idx_next    = '0;
                    sum_next    = '0;
                    req.rd_addr = '0;
                    state_next  = S_SCAN;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_SCAN:
            begin
                if (sum_ext >= {2'd0, need})
                begin
                    med_next   = idx_reg;
                    below_next = sum_reg;
                    emit_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (idx_reg == PIX_MAX)
                begin
                    med_next   = PIX_MAX;
                    below_next = sum_ext[BIN_W-1:0];
                    emit_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    sum_next    = sum_ext[BIN_W-1:0];
                    idx_next    = idx_reg + pix_t'(1);
                    req.rd_addr = idx_reg + pix_t'(1);
                end
            end
            S_WALK:
            begin
                if (below_reg > {1'b0, half})
                begin
                    if (med_reg != '0)
                    begin
                        idx_next    = med_reg - pix_t'(1);
                        req.rd_addr = med_reg - pix_t'(1);
                        state_next  = S_DOWN;
                    end
                    else
                    begin
                        emit_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (med_reg != PIX_MAX)
                begin
                    idx_next    = med_reg;
                    req.rd_addr = med_reg;
                    state_next  = S_UP;
                end
                else
                begin
                    emit_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DOWN:
            begin
                below_next = down_diff;
                med_next   = idx_reg;
                if (down_diff > {1'b0, half} && idx_reg != '0)
                begin
                    idx_next    = idx_reg - pix_t'(1);
                    req.rd_addr = idx_reg - pix_t'(1);
                end
                else
                begin
                    emit_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_UP:
            begin
                if (up_sum <= {2'd0, half})
                begin
                    below_next = up_sum[BIN_W-1:0];
                    med_next   = idx_reg + pix_t'(1);
                    if (idx_reg + pix_t'(1) != PIX_MAX)
                    begin
                        idx_next    = idx_reg + pix_t'(1);
                        req.rd_addr = idx_reg + pix_t'(1);
                    end
                    else
                    begin
                        emit_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    emit_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            emit_reg        <= 1'b0;
            below_reg       <= '0;
            med_reg         <= '0;
            err_reg         <= 1'b0;
            radius_reg      <= radius_t'(1);
            out_valid_reg   <= 1'b0;
            op_reg          <= 1'b0;
            last_reg        <= 1'b0;
            add_reg         <= '0;
            rem_reg         <= '0;
            idx_reg         <= '0;
            sum_reg         <= '0;
            median_reg      <= '0;
            count_error_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            emit_reg        <= emit_next;
            below_reg       <= below_next;
            med_reg         <= med_next;
            err_reg         <= err_next;
            radius_reg      <= radius_next;
            out_valid_reg   <= out_valid_next;
            op_reg          <= op_next;
            last_reg        <= last_next;
            add_reg         <= add_next;
            rem_reg         <= rem_next;
            idx_reg         <= idx_next;
            sum_reg         <= sum_next;
            median_reg      <= median_next;
            count_error_reg <= count_error_next;
        end
    end

    assign in_stall    = (state_reg != S_IDLE) || emit_reg;
    assign out_valid   = out_valid_reg;
    assign median      = median_reg;
    assign count_error = count_error_reg;

endmodule

@@ rtl/shm_ram.sv @@
// ----------------------------------------------------------------------------
// shm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module shm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/shm_bins.sv @@
// ----------------------------------------------------------------------------
// shm_bins
// Histogram bin store: RAM plus per-bin valid bits, so a bin never written
// since reset or since the last clear reads as zero, and a write bypass so a
// read issued with a write to the same bin returns the new count.
// ----------------------------------------------------------------------------
module shm_bins (
    input  logic             clk,
    input  logic             rst_n,
    input  shm_pkg::bin_req_t req,
    output shm_pkg::bin_t    bin_q
);

    import shm_pkg::*;

    logic [NUM_BINS-1:0] valid_reg;
    pix_t                rd_idx_reg;
    bin_t                ram_q;
    logic                fwd_reg;
    bin_t                fwd_data_reg;

    shm_ram #(
        .WIDTH (BIN_W),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data (req.wr_data),
        .rd_addr (req.rd_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.clear)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    // read of the bin being written sees the written count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg      <= 1'b0;
            fwd_data_reg <= '0;
        end
        else
        begin
            fwd_reg      <= req.wr_en && (req.wr_addr == req.rd_addr);
            fwd_data_reg <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= req.rd_addr;
    end

    assign bin_q = fwd_reg ? fwd_data_reg : (valid_reg[rd_idx_reg] ? ram_q : '0);

endmodule

@@ test/tb_sliding_histogram_median_unit.sv @@
// ----------------------------------------------------------------------------
// tb_sliding_histogram_median_unit
// Self-checking bench for the running median unit. A queue of pixel items
// (window loads, slides and some malformed traffic) feeds a driver; every
// accepted item is run through a histogram predictor, and each median that
// comes out is checked against the oldest predicted one. Both handshake sides
// idle at random, the receiver also holds off for a long stretch, and the
// radius is changed between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb_sliding_histogram_median_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import shm_pkg::*;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_SLIDE = 1'b1
    } pixel_op_e;

    typedef struct packed {
        pixel_op_e op;
        pix_t      add;
        pix_t      rem;
        logic      first;
        logic      last;
    } pixel_item_t;

    typedef struct packed {
        pix_t median;
        logic err;
    } median_rec_t;

    localparam int unsigned RUN_LIMIT_NS = 50_000_000;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    cfg_wr_en    = 1'b0;
    radius_t cfg_wr_data  = radius_t'(1);
    logic    in_valid     = 1'b0;
    logic    in_stall;
    logic    operation    = 1'b0;
    pix_t    add_pixel    = '0;
    pix_t    remove_pixel = '0;
    logic    first        = 1'b0;
    logic    last         = 1'b0;
    logic    out_valid;
    logic    out_stall    = 1'b0;
    pix_t    median;
    logic    count_error;

    logic    in_taken     = 1'b0;
    logic    out_hold     = 1'b0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      error_count   = 0;
    int      items_accepted = 0;

    pixel_item_t item_q[$];
    median_rec_t median_q[$];
    pix_t        win_pix[$];

    // predictor state
    bin_t    bin_count [NUM_BINS];
    int      below_cnt;
    pix_t    cur_median;
    logic    err_seen;
    radius_t radius_q;

    sliding_histogram_median_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .add_pixel    (add_pixel),
        .remove_pixel (remove_pixel),
        .first        (first),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .median       (median),
        .count_error  (count_error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int window_pixels();
        int r;
        r = (radius_q > RADIUS_CLIP) ? int'(RADIUS_CLIP) : int'(radius_q);
        return (2 * r + 1) * (2 * r + 1);
    endfunction

    function automatic bit bump_bin(pix_t v);
        if (bin_count[v] >= BIN_MAX)
        begin
            err_seen = 1'b1;
            return 1'b0;
        end
        bin_count[v] = bin_count[v] + 1'b1;
        return 1'b1;
    endfunction

    function automatic void apply_item(pixel_item_t it);
        int          need;
        int          sum;
        int          half;
        int          below;
        int          m;
        bit          found;
        bit          removed;
        median_rec_t rec;
        if (it.op == OP_LOAD)
        begin
            if (it.first)
            begin
                foreach (bin_count[i])
                    bin_count[i] = '0;
                below_cnt = 0;
            end
            void'(bump_bin(it.add));
        end
        else
        begin
            removed = 1'b0;
            if (bin_count[it.rem] == '0)
                err_seen = 1'b1;
            else
            begin
                bin_count[it.rem] = bin_count[it.rem] - 1'b1;
                removed = 1'b1;
            end
            if (removed && it.rem < cur_median && below_cnt > 0)
                below_cnt--;
            if (bump_bin(it.add) && it.add < cur_median && below_cnt < int'(CNT_MAX))
                below_cnt++;
        end
        if (!it.last)
            return;
        if (it.op == OP_LOAD)
        begin
            need  = (window_pixels() + 1) / 2;
            sum   = 0;
            found = 1'b0;
            for (int i = 0; i < NUM_BINS; i++)
            begin
                if (!found)
                begin
                    if (sum + int'(bin_count[i]) >= need)
                    begin
                        cur_median = pix_t'(i);
                        below_cnt  = sum;
                        found      = 1'b1;
                    end
                    else
                        sum += int'(bin_count[i]);
                end
            end
            if (!found)
            begin
                cur_median = PIX_MAX;
                below_cnt  = sum;
            end
        end
        else
        begin
            half  = window_pixels() / 2;
            below = below_cnt;
            m     = int'(cur_median);
            if (below > half)
            begin
                while (below > half && m > 0)
                begin
                    m--;
                    below = (below >= int'(bin_count[m])) ? below - int'(bin_count[m]) : 0;
                end
            end
            else
            begin
                while (m < NUM_BINS - 1 && below + int'(bin_count[m]) <= half)
                begin
                    below += int'(bin_count[m]);
                    m++;
                end
            end
            cur_median = pix_t'(m);
            below_cnt  = (below > int'(CNT_MAX)) ? int'(CNT_MAX) : below;
        end
        rec.median = cur_median;
        rec.err    = err_seen;
        median_q.push_back(rec);
        err_seen = 1'b0;
    endfunction

    function automatic void queue_item(pixel_op_e op, pix_t add, pix_t rem,
                                       logic first_f, logic last_f);
        pixel_item_t it;
        it.op    = op;
        it.add   = add;
        it.rem   = rem;
        it.first = first_f;
        it.last  = last_f;
        item_q.push_back(it);
    endfunction

    function automatic pix_t pick_pixel();
        case ($urandom_range(5))
            0: return '0;
            1: return PIX_MAX;
            2: return pix_t'($urandom_range(140, 120));
            default: return pix_t'($urandom_range(255));
        endcase
    endfunction

    // windows of random content: a full load (partial for large radii),
    // then slides that mostly remove pixels really in the window
    task automatic gen_windows(int budget);
        int   total;
        int   wsize;
        int   n;
        int   nslides;
        int   idx;
        pix_t a;
        pix_t r;
        total = 0;
        while (total < budget)
        begin
            wsize = window_pixels();
            n = (wsize > 121) ? $urandom_range(60, 20) : wsize;
            win_pix.delete();
            for (int i = 0; i < n; i++)
            begin
                a = pick_pixel();
                win_pix.push_back(a);
                queue_item(OP_LOAD, a, pix_t'($urandom),
                           (i == 0) ? ($urandom_range(15) != 0) : 1'b0,
                           (i == n - 1) || ($urandom_range(19) == 0));
            end
            nslides = $urandom_range(24, 4);
            for (int s = 0; s < nslides; s++)
            begin
                a = pick_pixel();
                if ($urandom_range(11) == 0 || win_pix.size() == 0)
                    r = pix_t'($urandom);
                else
                begin
                    idx = $urandom_range(win_pix.size() - 1);
                    r   = win_pix[idx];
                    win_pix.delete(idx);
                end
                win_pix.push_back(a);
                queue_item(OP_SLIDE, a, r, $urandom_range(9) == 0,
                           (s == nslides - 1) || ($urandom_range(9) < 6));
            end
            total += n + nslides;
        end
    endtask

    task automatic drain();
        wait (item_q.size() == 0);
        @(posedge clk);
        wait (!in_valid);
        wait (median_q.size() == 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_radius(radius_t r);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= r;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        radius_q = r;
    endtask

    // driver
    always @(negedge clk)
    begin : drive_items
        pixel_item_t nxt_item;
        if (!in_valid || in_taken)
        begin
            if (item_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt_item = item_q.pop_front();
                in_valid     <= 1'b1;
                operation    <= nxt_item.op;
                add_pixel    <= nxt_item.add;
                remove_pixel <= nxt_item.rem;
                first        <= nxt_item.first;
                last         <= nxt_item.last;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
        out_stall <= out_hold || ($urandom_range(99) < recv_idle_pct);

    // accepted items go through the predictor
    always @(posedge clk)
    begin : take_items
        pixel_item_t it;
        in_taken <= in_valid && !in_stall;
        if (in_valid && !in_stall)
        begin
            it.op    = pixel_op_e'(operation);
            it.add   = add_pixel;
            it.rem   = remove_pixel;
            it.first = first;
            it.last  = last;
            apply_item(it);
            items_accepted++;
        end
    end

    // monitor
    always @(posedge clk)
    begin : check_medians
        median_rec_t exp_rec;
        if (out_valid && !out_stall)
        begin
            if (median_q.size() == 0)
            begin
                $error("median result with none expected: median=%0d count_error=%0b",
                       median, count_error);
                error_count++;
            end
            else
            begin
                exp_rec = median_q.pop_front();
                if (median !== exp_rec.median)
                begin
                    $error("median: expected %0d, got %0d", exp_rec.median, median);
                    error_count++;
                end
                if (count_error !== exp_rec.err)
                begin
                    $error("count_error: expected %0b, got %0b", exp_rec.err, count_error);
                    error_count++;
                end
            end
        end
    end

    // long receiver hold-off while the sender keeps offering items
    initial
    begin
        wait (items_accepted >= 200);
        @(negedge clk);
        out_hold <= 1'b1;
        repeat (400) @(negedge clk);
        out_hold <= 1'b0;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("tb_sliding_histogram_median_unit failed");
        $finish;
    end

    initial
    begin
        foreach (bin_count[i])
            bin_count[i] = '0;
        below_cnt  = 0;
        cur_median = '0;
        err_seen   = 1'b0;
        radius_q   = radius_t'(1);

        send_idle_pct = 18;
        recv_idle_pct = 65;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed items at the reset radius
        queue_item(OP_LOAD, 8'd0, 8'd255, 1'b1, 1'b0);
        queue_item(OP_LOAD, 8'd255, 8'd0, 1'b0, 1'b0);
        queue_item(OP_LOAD, 8'hAA, 8'h55, 1'b0, 1'b0);
        queue_item(OP_LOAD, 8'h55, 8'hAA, 1'b0, 1'b0);
        queue_item(OP_LOAD, 8'd128, 8'd0, 1'b0, 1'b0);
        queue_item(OP_LOAD, 8'd127, 8'd0, 1'b0, 1'b0);
        queue_item(OP_LOAD, 8'd1, 8'd0, 1'b0, 1'b0);
        queue_item(OP_LOAD, 8'd254, 8'd0, 1'b0, 1'b0);
        queue_item(OP_LOAD, 8'd100, 8'd0, 1'b0, 1'b1);
        queue_item(OP_SLIDE, 8'd255, 8'd0, 1'b0, 1'b1);
        queue_item(OP_SLIDE, 8'd0, 8'd255, 1'b0, 1'b1);
        // empty bin removal, first ignored on a slide
        queue_item(OP_SLIDE, 8'd5, 8'd37, 1'b1, 1'b1);
        // too few pixels, then a walk pinned at the top bin
        queue_item(OP_LOAD, 8'd200, 8'd0, 1'b1, 1'b1);
        queue_item(OP_SLIDE, 8'd3, 8'd200, 1'b0, 1'b1);
        queue_item(OP_SLIDE, 8'd3, 8'd3, 1'b0, 1'b0);
        queue_item(OP_LOAD, 8'd9, 8'd0, 1'b0, 1'b1);
        drain();

        write_radius(radius_t'(0));
        gen_windows(60);
        drain();
        write_radius(radius_t'(2));
        gen_windows(160);
        drain();

        send_idle_pct = 65;
        recv_idle_pct = 18;
        write_radius(radius_t'(15));
        gen_windows(80);
        drain();
        write_radius(radius_t'(5));
        gen_windows(200);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_radius(radius_t'(1));
        gen_windows(120);
        drain();
        write_radius(radius_t'(3));
        gen_windows(120);
        drain();

        // empty bin removals, then a down walk to bin zero
        write_radius(radius_t'(0));
        queue_item(OP_LOAD, PIX_MAX, 8'd0, 1'b1, 1'b1);
        for (int i = 0; i < 8; i++)
            queue_item(OP_SLIDE, pix_t'(i % 2), 8'd128, 1'b0, 1'b0);
        queue_item(OP_SLIDE, 8'd0, 8'd128, 1'b0, 1'b1);
        drain();

        repeat (300) @(posedge clk);
        if (error_count == 0)
            $display("tb_sliding_histogram_median_unit passed");
        else
            $display("tb_sliding_histogram_median_unit failed");
        $finish;
    end

endmodule
